>>> src/pa_fit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pa_fit_pkg: shared types and constants of the partition allocator
// Table sizes, status and configuration codes, controller to datapath types.
// ----------------------------------------------------------------------------
package pa_fit_pkg;

  localparam int MaxParts = 16;
  localparam int SizeW    = 16;
  localparam int IdW      = 16;
  localparam int IdxW     = $clog2(MaxParts);
  localparam int CntW     = $clog2(MaxParts + 1);

  localparam logic [SizeW-1:0] TOTAL_RESET    = SizeW'(1024);
  localparam logic [SizeW-1:0] RESERVED_RESET = SizeW'(40);

  typedef enum logic [1:0] {
    CFG_TOTAL    = 2'd0,
    CFG_RESERVED = 2'd1,
    CFG_MODE     = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_ALT   = 2'd3
  } fit_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCAN,
    OP_ERROR,
    OP_ALLOC,
    OP_MARK,
    OP_MERGE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic early_err;
    logic is_free;
    logic scan_stop;
    logic found;
    logic merge_more;
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ALLOC,
    S_MARK,
    S_MERGE,
    S_RESULT
  } fsm_t;

endpackage

>>> src/partition_allocator_fit.sv
`timescale 1ns / 1ps
// allocate: check, table scan (up to the entry count, 16 at most), alloc, result
// register; free: check, scan, then mark and merges if the id is found, result
// register; a zero length or id zero request goes from check to the result
// throughput: one request at a time, paced by the one-entry-a-cycle table scan
// reset: table holds the reserved region and one free block, id counter 1
// ----------------------------------------------------------------------------
// partition_allocator_fit: variable partition allocator
// First, best or worst fit allocation with split, and free with neighbor
// merge, over an address-ordered partition table.
// ----------------------------------------------------------------------------
module partition_allocator_fit (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [pa_fit_pkg::SizeW-1:0]  req_length,
  input  logic [pa_fit_pkg::IdW-1:0]    req_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [pa_fit_pkg::IdW-1:0]    part_id,
  output logic [pa_fit_pkg::SizeW-1:0]  part_address,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [pa_fit_pkg::SizeW-1:0]  cfg_data
);

  pa_fit_pkg::dp_cmd_t  cmd;
  pa_fit_pkg::dp_stat_t stat;
  pa_fit_pkg::status_t  res_status;
  logic [pa_fit_pkg::IdW-1:0]   res_id;
  logic [pa_fit_pkg::SizeW-1:0] res_addr;
  logic res_push, out_free;

  // config writes must come only while idle; the block does not enforce this and always takes them
  assign cfg_ready = 1'b1;

  // output register frees up in the same cycle it is taken
  assign out_free = !out_valid || out_ready;

  pa_fit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .res_push (res_push),
    .cmd      (cmd)
  );

  pa_fit_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .req_length (req_length),
    .req_id     (req_id),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (res_status),
    .res_id     (res_id),
    .res_addr   (res_addr)
  );

  // result register, loaded when the sequencer hands over a finished request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      status       <= 2'(res_status);
      part_id      <= res_id;
      part_address <= res_addr;
    end
  end

  // one request in flight: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // a result is only handed over when the output register can take it
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!out_valid || out_ready))
    else $error("result overwrote a pending one");

  // failed requests never report an id or address
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != 2'(pa_fit_pkg::ST_OK)) |-> (part_id == '0 && part_address == '0))
    else $error("error result carries an id or address");

endmodule

>>> src/pa_fit_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pa_fit_ctrl: request sequencer
// Steps one request through check, table scan, update and result hand-off.
// ----------------------------------------------------------------------------
module pa_fit_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  pa_fit_pkg::dp_stat_t stat,
  output logic                 in_ready,
  output logic                 res_push,
  output pa_fit_pkg::dp_cmd_t  cmd
);

  pa_fit_pkg::fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pa_fit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pa_fit_pkg::S_IDLE: begin
        if (in_valid) state_next = pa_fit_pkg::S_CHECK;
      end
      pa_fit_pkg::S_CHECK: begin
        state_next = stat.early_err ? pa_fit_pkg::S_RESULT : pa_fit_pkg::S_SCAN;
      end
      pa_fit_pkg::S_SCAN: begin
        if (stat.scan_stop) begin
          if (!stat.is_free)  state_next = pa_fit_pkg::S_ALLOC;
          else if (stat.found) state_next = pa_fit_pkg::S_MARK;
          else                 state_next = pa_fit_pkg::S_RESULT;
        end
      end
      pa_fit_pkg::S_ALLOC:  state_next = pa_fit_pkg::S_RESULT;
      pa_fit_pkg::S_MARK:   state_next = pa_fit_pkg::S_MERGE;
      pa_fit_pkg::S_MERGE: begin
        if (!stat.merge_more) state_next = pa_fit_pkg::S_RESULT;
      end
      pa_fit_pkg::S_RESULT: begin
        if (out_free) state_next = pa_fit_pkg::S_IDLE;
      end
      default: state_next = pa_fit_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    res_push = 1'b0;
    cmd.op   = pa_fit_pkg::OP_IDLE;
    cmd.code = pa_fit_pkg::ST_OK;
    unique case (state)
      pa_fit_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = pa_fit_pkg::OP_LOAD;
      end
      pa_fit_pkg::S_CHECK: begin
        if (stat.early_err) begin
          cmd.op   = pa_fit_pkg::OP_ERROR;
          cmd.code = stat.is_free ? pa_fit_pkg::ST_NOTFOUND : pa_fit_pkg::ST_NOFIT;
        end
      end
      pa_fit_pkg::S_SCAN:   cmd.op = pa_fit_pkg::OP_SCAN;
      pa_fit_pkg::S_ALLOC:  cmd.op = pa_fit_pkg::OP_ALLOC;
      pa_fit_pkg::S_MARK:   cmd.op = pa_fit_pkg::OP_MARK;
      pa_fit_pkg::S_MERGE:  cmd.op = pa_fit_pkg::OP_MERGE;
      pa_fit_pkg::S_RESULT: res_push = out_free;
      default: ;
    endcase
  end

endmodule

>>> src/pa_fit_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pa_fit_dp: partition table datapath
// Holds the table, scans one entry a cycle, splits, frees and merges entries.
// ----------------------------------------------------------------------------
module pa_fit_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pa_fit_pkg::SizeW-1:0]  cfg_data,
  input  logic                          req_type,
  input  logic [pa_fit_pkg::SizeW-1:0]  req_length,
  input  logic [pa_fit_pkg::IdW-1:0]    req_id,
  input  pa_fit_pkg::dp_cmd_t           cmd,
  output pa_fit_pkg::dp_stat_t          stat,
  output pa_fit_pkg::status_t           res_status,
  output logic [pa_fit_pkg::IdW-1:0]    res_id,
  output logic [pa_fit_pkg::SizeW-1:0]  res_addr
);

  localparam int N    = pa_fit_pkg::MaxParts;
  localparam int SW   = pa_fit_pkg::SizeW;
  localparam int IW   = pa_fit_pkg::IdW;
  localparam int XW   = pa_fit_pkg::IdxW;
  localparam int CW   = pa_fit_pkg::CntW;

  logic [IW-1:0] ent_id    [N];
  logic [SW-1:0] ent_start [N];
  logic [SW-1:0] ent_len   [N];
  logic          ent_taken [N];
  logic [CW-1:0] count;
  logic [IW-1:0] id_ctr;

  logic [SW-1:0] total, reserved;
  pa_fit_pkg::fit_mode_t mode;

  logic          r_free;
  logic [SW-1:0] r_len;
  logic [IW-1:0] r_id;
  logic [XW-1:0] idx;
  logic          pick_v;
  logic [XW-1:0] pick_idx;
  logic [SW-1:0] pick_len, pick_start;
  logic [IW-1:0] pick_id;
  logic [SW-1:0] cur_len;

  // write-through view of the sizes for the rebuild
  logic [SW-1:0] new_total, new_res, free_len;
  logic          rebuild;

  logic [XW-1:0] rd_idx;
  logic [IW-1:0] rd_id;
  logic [SW-1:0] rd_len, rd_start;
  logic          rd_taken;
  logic          last, match, take, first_mode, fits, exact;
  logic [SW-1:0] sum_len;
  logic [IW-1:0] new_id;

  always_comb begin
    new_total = total;
    new_res   = reserved;
    rebuild   = cfg_we;
    unique case (pa_fit_pkg::cfg_idx_t'(cfg_index))
      pa_fit_pkg::CFG_TOTAL:    new_total = cfg_data;
      pa_fit_pkg::CFG_RESERVED: new_res   = cfg_data;
      pa_fit_pkg::CFG_MODE:     ;
      pa_fit_pkg::CFG_NONE:     rebuild   = 1'b0;
      default:                  rebuild   = 1'b0;
    endcase
    if (rst) begin
      new_total = pa_fit_pkg::TOTAL_RESET;
      new_res   = pa_fit_pkg::RESERVED_RESET;
    end
    free_len = (new_total > new_res) ? (new_total - new_res) : '0;
  end

  always_comb begin
    unique case (cmd.op)
      pa_fit_pkg::OP_MARK:  rd_idx = idx + 1'b1;
      pa_fit_pkg::OP_MERGE: rd_idx = idx - 1'b1;
      default:              rd_idx = idx;
    endcase
    rd_id    = ent_id[rd_idx];
    rd_len   = ent_len[rd_idx];
    rd_start = ent_start[rd_idx];
    rd_taken = ent_taken[rd_idx];
  end

  always_comb begin
    last       = (CW'(idx) == count - CW'(1));
    match      = (rd_id == r_id);
    first_mode = (mode == pa_fit_pkg::FIT_FIRST) || (mode == pa_fit_pkg::FIT_ALT);
    unique case (mode)
      pa_fit_pkg::FIT_WORST: take = !rd_taken && (!pick_v || rd_len > pick_len);
      pa_fit_pkg::FIT_BEST:  take = !rd_taken && rd_len >= r_len
                                    && (!pick_v || rd_len < pick_len);
      default:               take = !rd_taken && rd_len >= r_len;
    endcase
    fits    = pick_v && (pick_len >= r_len);
    exact   = (pick_len == r_len);
    new_id  = id_ctr + IW'(1);
    sum_len = rd_len + cur_len;

    stat.is_free    = r_free;
    stat.early_err  = r_free ? (r_id == '0) : (r_len == '0);
    stat.found      = match;
    stat.scan_stop  = r_free ? (match || last) : (last || (first_mode && take));
    stat.merge_more = (idx != '0) && !rd_taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= pa_fit_pkg::TOTAL_RESET;
      reserved <= pa_fit_pkg::RESERVED_RESET;
      mode     <= pa_fit_pkg::FIT_BEST;
    end else if (cfg_we) begin
      unique case (pa_fit_pkg::cfg_idx_t'(cfg_index))
        pa_fit_pkg::CFG_TOTAL:    total    <= cfg_data;
        pa_fit_pkg::CFG_RESERVED: reserved <= cfg_data;
        pa_fit_pkg::CFG_MODE:     mode     <= pa_fit_pkg::fit_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      ent_id[0]    <= '0;
      ent_start[0] <= '0;
      ent_len[0]   <= new_res;
      ent_taken[0] <= 1'b1;
      ent_id[1]    <= IW'(1);
      ent_start[1] <= new_res;
      ent_len[1]   <= free_len;
      ent_taken[1] <= 1'b0;
      count        <= CW'(2);
      id_ctr       <= IW'(1);
    end else begin
      unique case (cmd.op)
        pa_fit_pkg::OP_LOAD: begin
          r_free     <= req_type;
          r_len      <= req_length;
          r_id       <= req_id;
          idx        <= '0;
          pick_v     <= 1'b0;
          res_status <= pa_fit_pkg::ST_OK;
          res_id     <= '0;
          res_addr   <= '0;
        end
        pa_fit_pkg::OP_ERROR: res_status <= cmd.code;
        pa_fit_pkg::OP_SCAN: begin
          if (r_free) begin
            cur_len <= rd_len;
            if (!match && last) res_status <= pa_fit_pkg::ST_NOTFOUND;
          end else if (take) begin
            pick_v     <= 1'b1;
            pick_idx   <= idx;
            pick_len   <= rd_len;
            pick_start <= rd_start;
            pick_id    <= rd_id;
          end
          if (!stat.scan_stop) idx <= idx + 1'b1;
        end
        pa_fit_pkg::OP_ALLOC: begin
          if (!fits) begin
            res_status <= pa_fit_pkg::ST_NOFIT;
          end else if (exact) begin
            ent_taken[pick_idx] <= 1'b1;
            ent_id[pick_idx]    <= new_id;
            id_ctr              <= new_id;
            res_id              <= new_id;
            res_addr            <= pick_start;
          end else if (count == CW'(N)) begin
            res_status <= pa_fit_pkg::ST_FULL;
          end else begin
            // split: entries above the pick move up one place
            for (int j = 1; j < N; j++) begin
              if (j == int'(pick_idx) + 1) begin
                ent_id[j]    <= pick_id;
                ent_start[j] <= pick_start + r_len;
                ent_len[j]   <= pick_len - r_len;
                ent_taken[j] <= 1'b0;
              end else if (j > int'(pick_idx)) begin
                ent_id[j]    <= ent_id[j-1];
                ent_start[j] <= ent_start[j-1];
                ent_len[j]   <= ent_len[j-1];
                ent_taken[j] <= ent_taken[j-1];
              end
            end
            ent_id[pick_idx]    <= new_id;
            ent_len[pick_idx]   <= r_len;
            ent_taken[pick_idx] <= 1'b1;
            count               <= count + CW'(1);
            id_ctr              <= new_id;
            res_id              <= new_id;
            res_addr            <= pick_start;
          end
        end
        pa_fit_pkg::OP_MARK: begin
          ent_taken[idx] <= 1'b0;
          if ((CW'(idx) + CW'(1) < count) && !rd_taken) begin
            idx     <= rd_idx;
            cur_len <= rd_len;
          end
        end
        pa_fit_pkg::OP_MERGE: begin
          if (stat.merge_more) begin
            // fold the current entry into the one below and close the gap
            for (int j = 0; j < N; j++) begin
              if (j == int'(idx) - 1) begin
                ent_len[j] <= sum_len;
              end else if (j >= int'(idx) && j < N - 1) begin
                ent_id[j]    <= ent_id[j+1];
                ent_start[j] <= ent_start[j+1];
                ent_len[j]   <= ent_len[j+1];
                ent_taken[j] <= ent_taken[j+1];
              end
            end
            cur_len <= sum_len;
            count   <= count - CW'(1);
            idx     <= rd_idx;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
